/* design/bfp_pkg.sv */
// ============================================================================
// bfp_pkg
// Shared types for the point-to-barycentric weight pipeline.
// ============================================================================
package bfp_pkg;

    typedef struct packed {
        logic deg;
        logic neg_v;
        logic neg_w;
    } bfp_tag_t;

endpackage

/* design/bfp_div.sv */
// ============================================================================
// bfp_div
// Pipelined restoring divider, one quotient bit per stage, two numerators
// sharing one divisor.
// ============================================================================
module bfp_div #(
    parameter int NMW = 133,
    parameter int DVW = 105
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  bfp_pkg::bfp_tag_t in_tag,
    input  logic [NMW-1:0]    num_v,
    input  logic [NMW-1:0]    num_w,
    input  logic [DVW-1:0]    den,
    output logic              out_valid,
    output bfp_pkg::bfp_tag_t out_tag,
    output logic [NMW-1:0]    quo_v,
    output logic [NMW-1:0]    quo_w
);
    import bfp_pkg::*;

    logic             val_reg [0:NMW];
    bfp_tag_t         tag_reg [0:NMW];
    logic [DVW-1:0]   den_reg [0:NMW];
    logic [DVW-1:0]   rv_reg  [0:NMW];
    logic [DVW-1:0]   rw_reg  [0:NMW];
    logic [NMW-1:0]   nqv_reg [0:NMW];
    logic [NMW-1:0]   nqw_reg [0:NMW];

    always_comb
    begin
        val_reg[0] = in_valid;
        tag_reg[0] = in_tag;
        den_reg[0] = den;
        rv_reg[0]  = '0;
        rw_reg[0]  = '0;
        nqv_reg[0] = num_v;
        nqw_reg[0] = num_w;
    end

    for (genvar s = 0; s < NMW; s++)
    begin : g_stage
        logic [DVW:0]   shv;
        logic [DVW:0]   shw;
        logic           gev;
        logic           gew;
        logic [DVW-1:0] rv_next;
        logic [DVW-1:0] rw_next;

        always_comb
        begin
            shv     = {rv_reg[s], nqv_reg[s][NMW-1]};
            shw     = {rw_reg[s], nqw_reg[s][NMW-1]};
            gev     = shv >= {1'b0, den_reg[s]};
            gew     = shw >= {1'b0, den_reg[s]};
            rv_next = gev ? DVW'(shv - {1'b0, den_reg[s]}) : DVW'(shv);
            rw_next = gew ? DVW'(shw - {1'b0, den_reg[s]}) : DVW'(shw);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                val_reg[s+1] <= 1'b0;
            end
            else
            begin
                val_reg[s+1] <= val_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            tag_reg[s+1] <= tag_reg[s];
            den_reg[s+1] <= den_reg[s];
            rv_reg[s+1]  <= rv_next;
            rw_reg[s+1]  <= rw_next;
            nqv_reg[s+1] <= {nqv_reg[s][NMW-2:0], gev};
            nqw_reg[s+1] <= {nqw_reg[s][NMW-2:0], gew};
        end
    end

    assign out_valid = val_reg[NMW];
    assign out_tag   = tag_reg[NMW];
    assign quo_v     = nqv_reg[NMW];
    assign quo_w     = nqw_reg[NMW];

endmodule

/* design/barycentric_from_point.sv */
// ============================================================================
// barycentric_from_point
// Barycentric weights of a 3D point with respect to a triangle.
// ============================================================================
// Usage: drive the point and the three vertices and raise start for one
// cycle per beat. The block never raises busy, so a new beat may enter in
// every cycle. Each beat gives one result beat: weight_u, weight_v, weight_w
// (signed, WEIGHT_FRAC fraction bits, saturated) and degenerate, shown for
// one cycle while done is high.
// The wide multipliers have NC = ceil((2*COORD_WIDTH + 4) / 16) partial
// product stages, and the divider has NMW = 4*COORD_WIDTH + 9 + WEIGHT_FRAC
// stages, one quotient bit each.
// Throughput is one beat per cycle.
// Reset empties the pipeline; beats in flight are dropped and done stays low.
// The receiver cannot stall, so results leave in order on fixed latency.
// A degenerate triangle gives degenerate high and all weights zero.
// ============================================================================
module barycentric_from_point #(
    parameter int COORD_WIDTH = 24,
    parameter int WEIGHT_FRAC = 28
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    input  logic signed [COORD_WIDTH-1:0] vert_a_x,
    input  logic signed [COORD_WIDTH-1:0] vert_a_y,
    input  logic signed [COORD_WIDTH-1:0] vert_a_z,
    input  logic signed [COORD_WIDTH-1:0] vert_b_x,
    input  logic signed [COORD_WIDTH-1:0] vert_b_y,
    input  logic signed [COORD_WIDTH-1:0] vert_b_z,
    input  logic signed [COORD_WIDTH-1:0] vert_c_x,
    input  logic signed [COORD_WIDTH-1:0] vert_c_y,
    input  logic signed [COORD_WIDTH-1:0] vert_c_z,
    output logic                          done,
    output logic signed [31:0]            weight_u,
    output logic signed [31:0]            weight_v,
    output logic signed [31:0]            weight_w,
    output logic                          degenerate
);
    import bfp_pkg::*;

    localparam int EW   = COORD_WIDTH + 1;
    localparam int PW1  = 2 * EW;
    localparam int DTW  = 2 * EW + 2;
    localparam int CK   = 16;
    localparam int NC   = (DTW + CK - 1) / CK;
    localparam int PADW = NC * CK;
    localparam int SPW  = 2 * DTW + 1;
    localparam int NMW  = SPW + WEIGHT_FRAC;
    localparam int QW   = NMW + 3;
    localparam int LAT  = 11 + NC + NMW;

    localparam int PAIR_A [0:5] = '{0, 1, 2, 1, 0, 1};
    localparam int PAIR_B [0:5] = '{2, 1, 3, 4, 4, 3};

    localparam logic signed [NMW+1:0] ONE = (NMW+2)'(1) << WEIGHT_FRAC;

    function automatic logic [2*DTW-1:0] part_prod(input logic [DTW-1:0] a,
                                                   input logic [DTW-1:0] b,
                                                   input int k);
        logic [PADW-1:0]   bp;
        logic [CK-1:0]     ch;
        logic [DTW+CK-1:0] pr;
        bp = PADW'(b);
        ch = bp[k*CK +: CK];
        pr = {{CK{1'b0}}, a} * {{DTW{1'b0}}, ch};
        return (2*DTW)'(pr) << (k * CK);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [QW-1:0] x);
        logic [QW-32:0] hi;
        hi = x[QW-1:31];
        if ((&hi) || !(|hi))
        begin
            return x[31:0];
        end
        return x[QW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    logic signed [COORD_WIDTH-1:0] pp [0:2];
    logic signed [COORD_WIDTH-1:0] pa [0:2];
    logic signed [COORD_WIDTH-1:0] pb [0:2];
    logic signed [COORD_WIDTH-1:0] pc [0:2];

    assign pp = '{point_x, point_y, point_z};
    assign pa = '{vert_a_x, vert_a_y, vert_a_z};
    assign pb = '{vert_b_x, vert_b_y, vert_b_z};
    assign pc = '{vert_c_x, vert_c_y, vert_c_z};

    assign busy = 1'b0;

    // Edge vectors.
    logic                 v1_reg;
    logic signed [EW-1:0] e0_reg [0:2];
    logic signed [EW-1:0] e1_reg [0:2];
    logic signed [EW-1:0] e2_reg [0:2];
    // Coordinate products.
    logic                  v2_reg;
    logic signed [PW1-1:0] m_reg [0:4][0:2];
    // Dot products.
    logic                  v3_reg;
    logic signed [DTW-1:0] dot_reg [0:4];
    // Partial product stages; index 0 holds magnitudes and signs.
    logic                  cval_reg [0:NC];
    logic [DTW-1:0]        cmag_reg [0:NC][0:4];
    logic                  csgn_reg [0:NC][0:4];
    logic [2*DTW-1:0]      cacc_reg [0:NC][0:5];
    // Signed wide products, then den, nv and nw.
    logic                  vsg_reg;
    logic signed [SPW-1:0] sp_reg [0:5];
    logic                  vsb_reg;
    logic signed [SPW:0]   den_reg;
    logic signed [SPW:0]   nv_reg;
    logic signed [SPW:0]   nw_reg;
    // Divider operands.
    logic                  vpr_reg;
    bfp_tag_t              tpr_reg;
    logic [NMW-1:0]        numv_reg;
    logic [NMW-1:0]        numw_reg;
    logic [SPW-1:0]        dvs_reg;
    // Divider results and final stages.
    logic                  dv_valid;
    bfp_tag_t              dv_tag;
    logic [NMW-1:0]        dv_qv;
    logic [NMW-1:0]        dv_qw;
    logic                  vf1_reg;
    logic                  vf2_reg;
    logic                  vf3_reg;
    logic                  deg1_reg;
    logic                  deg2_reg;
    logic                  deg3_reg;
    logic signed [NMW:0]   qv1_reg;
    logic signed [NMW:0]   qw1_reg;
    logic signed [NMW+1:0] t2_reg;
    logic signed [NMW:0]   qw2_reg;
    logic [31:0]           sv2_reg;
    logic [31:0]           sw2_reg;
    logic signed [QW-1:0]  qu3_reg;
    logic [31:0]           sv3_reg;
    logic [31:0]           sw3_reg;
    logic                  done_reg;
    logic [31:0]           wu_reg;
    logic [31:0]           wv_reg;
    logic [31:0]           ww_reg;
    logic                  deg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            cval_reg[0] <= 1'b0;
            vsg_reg     <= 1'b0;
            vsb_reg     <= 1'b0;
            vpr_reg     <= 1'b0;
            vf1_reg     <= 1'b0;
            vf2_reg     <= 1'b0;
            vf3_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            v1_reg      <= start && !busy;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            cval_reg[0] <= v3_reg;
            vsg_reg     <= cval_reg[NC];
            vsb_reg     <= vsg_reg;
            vpr_reg     <= vsb_reg;
            vf1_reg     <= dv_valid;
            vf2_reg     <= vf1_reg;
            vf3_reg     <= vf2_reg;
            done_reg    <= vf3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            e0_reg[k] <= {pb[k][COORD_WIDTH-1], pb[k]} - {pa[k][COORD_WIDTH-1], pa[k]};
            e1_reg[k] <= {pc[k][COORD_WIDTH-1], pc[k]} - {pa[k][COORD_WIDTH-1], pa[k]};
            e2_reg[k] <= {pp[k][COORD_WIDTH-1], pp[k]} - {pa[k][COORD_WIDTH-1], pa[k]};
            m_reg[0][k] <= PW1'(e0_reg[k]) * PW1'(e0_reg[k]);
            m_reg[1][k] <= PW1'(e0_reg[k]) * PW1'(e1_reg[k]);
            m_reg[2][k] <= PW1'(e1_reg[k]) * PW1'(e1_reg[k]);
            m_reg[3][k] <= PW1'(e2_reg[k]) * PW1'(e0_reg[k]);
            m_reg[4][k] <= PW1'(e2_reg[k]) * PW1'(e1_reg[k]);
        end
        for (int i = 0; i < 5; i++)
        begin
            dot_reg[i] <= {{2{m_reg[i][0][PW1-1]}}, m_reg[i][0]}
                        + {{2{m_reg[i][1][PW1-1]}}, m_reg[i][1]}
                        + {{2{m_reg[i][2][PW1-1]}}, m_reg[i][2]};
            cmag_reg[0][i] <= dot_reg[i][DTW-1] ? DTW'(-dot_reg[i]) : DTW'(dot_reg[i]);
            csgn_reg[0][i] <= dot_reg[i][DTW-1];
        end
        for (int j = 0; j < 6; j++)
        begin
            cacc_reg[0][j] <= '0;
            if (csgn_reg[NC][PAIR_A[j]] ^ csgn_reg[NC][PAIR_B[j]])
            begin
                sp_reg[j] <= -$signed({1'b0, cacc_reg[NC][j]});
            end
            else
            begin
                sp_reg[j] <= $signed({1'b0, cacc_reg[NC][j]});
            end
        end
        den_reg <= {sp_reg[0][SPW-1], sp_reg[0]} - {sp_reg[1][SPW-1], sp_reg[1]};
        nv_reg  <= {sp_reg[2][SPW-1], sp_reg[2]} - {sp_reg[3][SPW-1], sp_reg[3]};
        nw_reg  <= {sp_reg[4][SPW-1], sp_reg[4]} - {sp_reg[5][SPW-1], sp_reg[5]};
        tpr_reg.deg   <= den_reg == '0;
        tpr_reg.neg_v <= nv_reg[SPW];
        tpr_reg.neg_w <= nw_reg[SPW];
        numv_reg <= {(nv_reg[SPW] ? SPW'(-nv_reg) : SPW'(nv_reg)), {WEIGHT_FRAC{1'b0}}};
        numw_reg <= {(nw_reg[SPW] ? SPW'(-nw_reg) : SPW'(nw_reg)), {WEIGHT_FRAC{1'b0}}};
        dvs_reg  <= den_reg[SPW-1:0];
        deg1_reg <= dv_tag.deg;
        qv1_reg  <= dv_tag.neg_v ? -$signed({1'b0, dv_qv}) : $signed({1'b0, dv_qv});
        qw1_reg  <= dv_tag.neg_w ? -$signed({1'b0, dv_qw}) : $signed({1'b0, dv_qw});
        deg2_reg <= deg1_reg;
        t2_reg   <= ONE - {qv1_reg[NMW], qv1_reg};
        qw2_reg  <= qw1_reg;
        sv2_reg  <= sat32({{2{qv1_reg[NMW]}}, qv1_reg});
        sw2_reg  <= sat32({{2{qw1_reg[NMW]}}, qw1_reg});
        deg3_reg <= deg2_reg;
        qu3_reg  <= {t2_reg[NMW+1], t2_reg} - {{2{qw2_reg[NMW]}}, qw2_reg};
        sv3_reg  <= sv2_reg;
        sw3_reg  <= sw2_reg;
        deg_reg  <= deg3_reg;
        wu_reg   <= deg3_reg ? 32'h0 : sat32(qu3_reg);
        wv_reg   <= deg3_reg ? 32'h0 : sv3_reg;
        ww_reg   <= deg3_reg ? 32'h0 : sw3_reg;
    end

    for (genvar k = 0; k < NC; k++)
    begin : g_chunk
        logic [2*DTW-1:0] acc_next [0:5];

        always_comb
        begin
            for (int j = 0; j < 6; j++)
            begin
                acc_next[j] = cacc_reg[k][j]
                            + part_prod(cmag_reg[k][PAIR_A[j]], cmag_reg[k][PAIR_B[j]], k);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cval_reg[k+1] <= 1'b0;
            end
            else
            begin
                cval_reg[k+1] <= cval_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            cmag_reg[k+1] <= cmag_reg[k];
            csgn_reg[k+1] <= csgn_reg[k];
            cacc_reg[k+1] <= acc_next;
        end
    end

    bfp_div #(
        .NMW (NMW),
        .DVW (SPW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vpr_reg),
        .in_tag    (tpr_reg),
        .num_v     (numv_reg),
        .num_w     (numw_reg),
        .den       (dvs_reg),
        .out_valid (dv_valid),
        .out_tag   (dv_tag),
        .quo_v     (dv_qv),
        .quo_w     (dv_qw)
    );

    assign done       = done_reg;
    assign weight_u   = wu_reg;
    assign weight_v   = wv_reg;
    assign weight_w   = ww_reg;
    assign degenerate = deg_reg;

    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("accepted beat did not produce a result on time");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##LAT !done)
        else $error("result beat without an accepted input beat");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && degenerate |-> weight_u == 0 && weight_v == 0 && weight_w == 0)
        else $error("degenerate result carries nonzero weights");

endmodule

/* sim/barycentric_from_point_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// barycentric_from_point_tb
// This testbench checks the barycentric weights computed for a point and a
// triangle. Each accepted beat is run through a predictor that uses exact
// 256-bit integer arithmetic. The expected weights are queued and compared
// in order with the result beats. The stimulus covers directed corner cases
// (extreme coordinates, degenerate and nearly degenerate triangles) and then
// random triangles of several scales, with random gaps between beats.
// ============================================================================
module barycentric_from_point_tb;

    localparam int CW = 24;
    localparam int WF = 28;

    typedef logic signed [255:0] wide_t;
    typedef logic signed [CW-1:0] coord_t;

    typedef struct {
        coord_t p[3];
        coord_t a[3];
        coord_t b[3];
        coord_t c[3];
    } query_t;

    typedef struct {
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic signed [31:0] w;
        logic               deg;
    } weights_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    coord_t point_x, point_y, point_z;
    coord_t vert_a_x, vert_a_y, vert_a_z;
    coord_t vert_b_x, vert_b_y, vert_b_z;
    coord_t vert_c_x, vert_c_y, vert_c_z;
    logic done;
    logic signed [31:0] weight_u, weight_v, weight_w;
    logic degenerate;

    weights_t weight_q[$];
    int       fail_count;

    barycentric_from_point #(
        .COORD_WIDTH(CW),
        .WEIGHT_FRAC(WF)
    ) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .vert_a_x(vert_a_x), .vert_a_y(vert_a_y), .vert_a_z(vert_a_z),
        .vert_b_x(vert_b_x), .vert_b_y(vert_b_y), .vert_b_z(vert_b_z),
        .vert_c_x(vert_c_x), .vert_c_y(vert_c_y), .vert_c_z(vert_c_z),
        .done(done), .weight_u(weight_u), .weight_v(weight_v),
        .weight_w(weight_w), .degenerate(degenerate)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic signed [31:0] sat32(wide_t x);
        wide_t hi;
        wide_t lo;
        hi = 2147483647;
        lo = -(wide_t'(1) <<< 31);
        if (x > hi)
            return 32'sh7fffffff;
        if (x < lo)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic wide_t dot3(wide_t x[3], wide_t y[3]);
        return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
    endfunction

    function automatic weights_t barycentric_weights(query_t q);
        wide_t e0[3], e1[3], e2[3];
        wide_t d00, d01, d11, d20, d21, den, nv, nw, qv, qw, qu;
        weights_t r;
        for (int k = 0; k < 3; k++)
        begin
            e0[k] = wide_t'(q.b[k]) - wide_t'(q.a[k]);
            e1[k] = wide_t'(q.c[k]) - wide_t'(q.a[k]);
            e2[k] = wide_t'(q.p[k]) - wide_t'(q.a[k]);
        end
        d00 = dot3(e0, e0);
        d01 = dot3(e0, e1);
        d11 = dot3(e1, e1);
        d20 = dot3(e2, e0);
        d21 = dot3(e2, e1);
        den = d00 * d11 - d01 * d01;
        if (den == 0)
        begin
            r.u = 0;
            r.v = 0;
            r.w = 0;
            r.deg = 1'b1;
            return r;
        end
        nv = (d11 * d20 - d01 * d21) <<< WF;
        nw = (d00 * d21 - d01 * d20) <<< WF;
        qv = nv / den;
        qw = nw / den;
        qu = (wide_t'(1) <<< WF) - qv - qw;
        r.u = sat32(qu);
        r.v = sat32(qv);
        r.w = sat32(qw);
        r.deg = 1'b0;
        return r;
    endfunction

    // The inputs are driven with nonblocking assignments, so at the edge they
    // still hold the beat that this edge accepts.
    always @(posedge clk)
    begin
        query_t q;
        q.p = '{point_x, point_y, point_z};
        q.a = '{vert_a_x, vert_a_y, vert_a_z};
        q.b = '{vert_b_x, vert_b_y, vert_b_z};
        q.c = '{vert_c_x, vert_c_y, vert_c_z};
        if (rst_n && start && !busy)
            weight_q.push_back(barycentric_weights(q));
    end

    always @(posedge clk)
    begin
        weights_t e;
        if (rst_n && done)
        begin
            if (weight_q.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                fail_count++;
            end
            else
            begin
                e = weight_q.pop_front();
                if (weight_u !== e.u)
                begin
                    $error("weight_u expected %0d actual %0d", e.u, weight_u);
                    fail_count++;
                end
                if (weight_v !== e.v)
                begin
                    $error("weight_v expected %0d actual %0d", e.v, weight_v);
                    fail_count++;
                end
                if (weight_w !== e.w)
                begin
                    $error("weight_w expected %0d actual %0d", e.w, weight_w);
                    fail_count++;
                end
                if (degenerate !== e.deg)
                begin
                    $error("degenerate expected %0b actual %0b", e.deg, degenerate);
                    fail_count++;
                end
            end
        end
    end

    bit no_gaps;

    task automatic send_query(query_t q);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        {point_x, point_y, point_z} <= {q.p[0], q.p[1], q.p[2]};
        {vert_a_x, vert_a_y, vert_a_z} <= {q.a[0], q.a[1], q.a[2]};
        {vert_b_x, vert_b_y, vert_b_z} <= {q.b[0], q.b[1], q.b[2]};
        {vert_c_x, vert_c_y, vert_c_z} <= {q.c[0], q.c[1], q.c[2]};
        do
            @(posedge clk);
        while (busy);
    endtask

    function automatic query_t make_query(coord_t p[3], coord_t a[3], coord_t b[3],
                                          coord_t c[3]);
        query_t q;
        q.p = p;
        q.a = a;
        q.b = b;
        q.c = c;
        return q;
    endfunction

    localparam coord_t CMAX = 24'sh7fffff;
    localparam coord_t CMIN = 24'sh800000;
    localparam coord_t ONE  = 24'sh010000;

    task automatic test_degenerate();
        coord_t two;
        two = coord_t'(2 * ONE);
        send_query(make_query('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}));
        send_query(make_query('{CMAX, CMIN, 5}, '{7, 7, 7}, '{7, 7, 7}, '{7, 7, 7}));
        send_query(make_query('{1, 2, 3}, '{0, 0, 0}, '{ONE, ONE, ONE},
                              '{two, two, two}));
        send_query(make_query('{0, 0, 0}, '{CMIN, CMIN, CMIN}, '{CMAX, CMAX, CMAX},
                              '{CMIN, CMIN, CMIN}));
    endtask

    task automatic test_unit_triangle();
        coord_t a[3], b[3], c[3];
        coord_t third;
        coord_t three;
        a = '{0, 0, 0};
        b = '{ONE, 0, 0};
        c = '{0, ONE, 0};
        third = coord_t'(ONE / 3);
        three = coord_t'(3 * ONE);
        send_query(make_query(a, a, b, c));
        send_query(make_query(b, a, b, c));
        send_query(make_query(c, a, b, c));
        send_query(make_query('{third, third, 0}, a, b, c));
        send_query(make_query('{-ONE, three, ONE}, a, b, c));
        send_query(make_query('{CMAX, CMIN, CMAX}, a, b, c));
        send_query(make_query('{CMIN, CMAX, CMIN}, a, b, c));
    endtask

    task automatic test_extremes();
        coord_t near_max;
        near_max = coord_t'(CMAX - 1);
        send_query(make_query('{CMAX, CMAX, CMAX}, '{CMIN, CMIN, CMIN},
                              '{CMAX, CMIN, CMIN}, '{CMIN, CMAX, CMIN}));
        send_query(make_query('{CMIN, CMIN, CMIN}, '{CMAX, CMAX, CMAX},
                              '{CMIN, CMAX, CMAX}, '{CMAX, CMIN, CMAX}));
        send_query(make_query('{-1, -1, -1}, '{CMIN, 0, CMAX},
                              '{CMAX, CMIN, 0}, '{0, CMAX, CMIN}));
        // Nearly collinear vertices give huge quotients that saturate.
        send_query(make_query('{CMAX, CMIN, 0}, '{0, 0, 0}, '{CMAX, CMAX, 0},
                              '{CMAX, near_max, 0}));
        send_query(make_query('{CMIN, CMAX, 0}, '{0, 0, 0}, '{1, 0, 0}, '{2, 1, 0}));
        send_query(make_query('{CMAX, CMAX, CMAX}, '{0, 0, 0}, '{1, 0, 0}, '{0, 1, 0}));
    endtask

    function automatic coord_t random_coord(int scale);
        case (scale)
            0: return coord_t'($urandom);
            1: return coord_t'(int'($urandom_range(0, 8191)) - 4096);
            default: return coord_t'(int'($urandom_range(0, 15)) - 8);
        endcase
    endfunction

    task automatic test_random(int count);
        query_t q;
        int scale;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            scale = $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 2);
            for (int k = 0; k < 3; k++)
            begin
                q.p[k] = random_coord(scale);
                q.a[k] = random_coord(scale);
                q.b[k] = random_coord(scale);
                q.c[k] = random_coord(scale);
            end
            case ($urandom_range(0, 9))
                0: q.c = q.b;
                1: q.b = q.a;
                2: for (int k = 0; k < 3; k++) q.c[k] = q.b[k] + (q.b[k] - q.a[k]);
                3: q.c[0] = coord_t'(q.b[0] + 1);
                default: ;
            endcase
            send_query(q);
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_drain_pause();
        start <= 1'b0;
        while (weight_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        fail_count = 0;
        no_gaps = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        {point_x, point_y, point_z} = '0;
        {vert_a_x, vert_a_y, vert_a_z} = '0;
        {vert_b_x, vert_b_y, vert_b_z} = '0;
        {vert_c_x, vert_c_y, vert_c_z} = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_degenerate();
        test_unit_triangle();
        test_extremes();
        test_random(260);
        test_drain_pause();
        test_random(270);
        start <= 1'b0;
        while (weight_q.size() != 0)
            @(posedge clk);
        repeat (160) @(posedge clk);
        if (fail_count == 0)
            $display("barycentric_from_point_tb OK");
        else
            $display("barycentric_from_point_tb NOT OK");
        $finish;
    end

    initial
    begin
        #400000;
        $display("barycentric_from_point_tb NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
design/bfp_pkg.sv
design/bfp_div.sv
design/barycentric_from_point.sv
sim/barycentric_from_point_tb.sv
